// ===== rtl/nbsf_pkg.sv =====
// Shared widths, register indexes, types and helpers of the byte sequence finder.
`default_nettype none
package nbsf_pkg;

   localparam int unsigned OFF_W      = 64;
   localparam int unsigned OCC_W      = 32;
   localparam int unsigned PLEN_W     = 5;
   localparam int unsigned PAT_BYTES  = 16;
   localparam int unsigned PAT_W      = 8 * PAT_BYTES;
   localparam int unsigned CSR_IDX_W  = 3;
   localparam int unsigned CSR_DATA_W = 64;
   localparam int unsigned POS_W      = 7;

   localparam logic [CSR_IDX_W-1:0] CSR_OCCURRENCE = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_START      = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_END        = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_DATA_SIZE  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_PAT_LEN    = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_PAT_LOW    = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_PAT_HIGH   = 3'd6;

   typedef struct packed {
      logic              shift;
      logic              clear;
      logic [PLEN_W-1:0] len;
   } cell_ctrl_type;

   typedef struct packed {
      logic             found;
      logic [OFF_W-1:0] match_offset;
   } result_type;

   // Pattern byte at a position; positions past the stored pattern read as zero.
   function automatic logic [7:0] pat_sel(input logic [PAT_W-1:0] pattern,
                                          input logic [POS_W-1:0] idx);
      logic [7:0] value;
      value = 8'd0;
      if (idx < POS_W'(PAT_BYTES)) begin
         value = pattern[idx[3:0]*8 +: 8];
      end
      return value;
   endfunction

endpackage
`default_nettype wire

// ===== rtl/nbsf_if.sv =====
// Valid/ready channel interfaces for data bytes in and search results out.
`default_nettype none
interface nbsf_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       first;

   modport source (output valid, output data_byte, output first, input ready);
   modport sink (input valid, input data_byte, input first, output ready);
endinterface

interface nbsf_rsp_if;
   import nbsf_pkg::*;
   logic             valid;
   logic             ready;
   logic             found;
   logic [OFF_W-1:0] match_offset;

   modport source (output valid, output found, output match_offset, input ready);
   modport sink (input valid, input found, input match_offset, output ready);
endinterface
`default_nettype wire

// ===== rtl/nbsf_cell.sv =====
// One window cell: holds a byte, passes it on and compares it with its pattern byte.
`default_nettype none
module nbsf_cell #(
   parameter int unsigned POS = 0
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire nbsf_pkg::cell_ctrl_type ctrl,
   input  wire logic [nbsf_pkg::PAT_W-1:0] pattern,
   input  wire logic [7:0]            byte_in,
   input  wire logic                  valid_in,
   output logic [7:0]                 byte_out,
   output logic                       valid_out,
   output logic                       ok
);
   import nbsf_pkg::*;

   localparam logic [POS_W-1:0] POS_P1 = POS_W'(POS + 1);
   localparam bit               HEAD   = (POS == 0);

   logic [7:0]       byte_ff;
   logic             valid_ff;
   logic             valid_in_eff;
   logic             enabled;
   logic [POS_W-1:0] pat_idx;
   logic [POS_W-1:0] len_w;

   assign len_w   = {{(POS_W-PLEN_W){1'b0}}, ctrl.len};
   // The cell takes part when the pattern reaches back this far into the window.
   assign enabled = len_w > POS_P1;
   assign pat_idx = len_w - POS_P1 - POS_W'(1);

   // A restart empties the window, so only the head cell keeps what it is given.
   assign valid_in_eff = valid_in && (HEAD || !ctrl.clear);

   always_ff @(posedge clock) begin
      if (ctrl.shift) begin
         byte_ff <= byte_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (ctrl.shift) begin
         valid_ff <= valid_in_eff;
      end else if (ctrl.clear) begin
         valid_ff <= 1'b0;
      end
   end

   assign ok = !enabled ||
               (valid_ff && !ctrl.clear && (byte_ff == pat_sel(pattern, pat_idx)));
   assign byte_out  = byte_ff;
   assign valid_out = valid_ff;

endmodule
`default_nettype wire

// ===== rtl/nbsf_out_buf.sv =====
// Two-entry result buffer between the search logic and the result channel.
`default_nettype none
module nbsf_out_buf (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 push,
   input  wire nbsf_pkg::result_type push_data,
   output logic                      has_room,
   nbsf_rsp_if.source                rsp
);
   import nbsf_pkg::*;

   result_type entry_ff [2];
   logic       wr_ptr_ff;
   logic       wr_ptr_in;
   logic       rd_ptr_ff;
   logic       rd_ptr_in;
   logic [1:0] count_ff;
   logic [1:0] count_in;
   logic       pop;

   assign pop      = rsp.valid && rsp.ready;
   assign has_room = (count_ff != 2'd2);

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ pop;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   assign rsp.valid        = (count_ff != 2'd0);
   assign rsp.found        = entry_ff[rd_ptr_ff].found;
   assign rsp.match_offset = entry_ff[rd_ptr_ff].match_offset;

endmodule
`default_nettype wire

// ===== rtl/nth_byte_sequence_finder.sv =====
// Streaming search for the n-th occurrence of a byte pattern in a byte range.
//
// Data bytes enter on req_bus in address order, one word per byte; first marks the
// byte at the configured start offset and restarts the search. The csr_ port writes
// the occurrence index, range bounds, data size and up to sixteen pattern bytes.
// Each search yields exactly one word on rsp_bus: found with the start offset of the
// wanted match, or not found when the range ends first (or is empty on the first
// byte). Bytes outside a search give nothing.
// Throughput is one byte per cycle while the output buffer has room: the window cells
// compare in parallel and the offset and match count update in that same cycle. A
// result is buffered in the cycle after its byte, shown at once if none waits ahead.
// The output buffer holds two results, so req_bus stays ready while one result
// waits; it stalls only when two results are waiting for the receiver.
// Reset (synchronous, active high) clears the registers, the search state, the
// window valid bits and the output buffer.
`default_nettype none
module nth_byte_sequence_finder #(
   parameter int unsigned MAX_PATTERN = 16
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   nbsf_req_if.sink                            req_bus,
   nbsf_rsp_if.source                          rsp_bus,
   input  wire logic                           csr_wr_en,
   input  wire logic [nbsf_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [nbsf_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import nbsf_pkg::*;

   localparam int unsigned      WIN_DEPTH = MAX_PATTERN - 1;
   localparam logic [POS_W-1:0] MAX_P    = POS_W'(MAX_PATTERN);

   // Configuration registers.
   logic [OCC_W-1:0]  occ_ff;
   logic [OFF_W-1:0]  start_ff;
   logic [OFF_W-1:0]  end_ff;
   logic [OFF_W-1:0]  size_ff;
   logic [PLEN_W-1:0] plen_ff;
   logic [OFF_W-1:0]  pat_lo_ff;
   logic [OFF_W-1:0]  pat_hi_ff;

   // Search state.
   logic              search_ff;
   logic              search_in;
   logic [OFF_W-1:0]  cur_ff;
   logic [OFF_W-1:0]  cur_in;
   logic [OCC_W-1:0]  cnt_ff;
   logic [OCC_W-1:0]  cnt_in;

   logic              acc;
   logic              first;
   logic [7:0]        data;
   logic              empty;
   logic [PLEN_W-1:0] len;
   logic [PLEN_W-1:0] len_m1;
   logic              act;
   logic              step;
   logic              hit;
   logic              win;
   logic              stop;
   logic [OFF_W-1:0]  cur_eff;
   logic [OCC_W-1:0]  cnt_eff;
   logic [OFF_W:0]    next_off;
   logic [OFF_W:0]    lim_off;
   logic [PAT_W-1:0]  pattern;
   logic              top_ok;
   logic              res_push;
   result_type        res_data;
   logic              has_room;
   cell_ctrl_type     ctrl;

   logic [7:0]           cell_byte  [WIN_DEPTH];
   logic                 cell_valid [WIN_DEPTH];
   logic [WIN_DEPTH-1:0] cell_ok;

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff    <= '0;
         start_ff  <= '0;
         end_ff    <= '0;
         size_ff   <= '0;
         plen_ff   <= '0;
         pat_lo_ff <= '0;
         pat_hi_ff <= '0;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_OCCURRENCE: occ_ff    <= csr_wdata[OCC_W-1:0];
            CSR_START:      start_ff  <= csr_wdata;
            CSR_END:        end_ff    <= csr_wdata;
            CSR_DATA_SIZE:  size_ff   <= csr_wdata;
            CSR_PAT_LEN:    plen_ff   <= csr_wdata[PLEN_W-1:0];
            CSR_PAT_LOW:    pat_lo_ff <= csr_wdata;
            CSR_PAT_HIGH:   pat_hi_ff <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   assign pattern = {pat_hi_ff, pat_lo_ff};
   assign acc     = req_bus.valid && req_bus.ready;
   assign first   = req_bus.first;
   assign data    = req_bus.data_byte;

   always_comb begin
      empty   = (start_ff >= end_ff) || (size_ff == '0) || (plen_ff == '0);
      len     = ({{(POS_W-PLEN_W){1'b0}}, plen_ff} > MAX_P) ? MAX_P[PLEN_W-1:0] : plen_ff;
      len_m1  = len - PLEN_W'(1);
      act     = acc && (first ? !empty : search_ff);
      step    = act && (len != '0);
      cur_eff = first ? start_ff : cur_ff;
      cnt_eff = first ? '0 : cnt_ff;
      top_ok  = (data == pat_sel(pattern, {{(POS_W-PLEN_W){1'b0}}, len_m1}));
      hit     = step && top_ok && (&cell_ok);
      win     = hit && (cnt_eff >= occ_ff);
      // The wide sums keep an offset wrap past the top of the address space visible.
      next_off = {1'b0, cur_eff} + (OFF_W+1)'(1);
      lim_off  = {1'b0, start_ff} + {1'b0, size_ff};
      stop     = (next_off >= {1'b0, end_ff}) ||
                 ((start_ff < end_ff) && (next_off >= lim_off));
   end

   always_comb begin
      res_push              = 1'b0;
      res_data.found        = 1'b0;
      res_data.match_offset = '0;
      if (acc && first && empty) begin
         res_push = 1'b1;
      end else if (act && !step) begin
         res_push = 1'b1;
      end else if (win) begin
         res_push              = 1'b1;
         res_data.found        = 1'b1;
         res_data.match_offset = cur_eff - {{(OFF_W-PLEN_W){1'b0}}, len_m1};
      end else if (step && stop) begin
         res_push = 1'b1;
      end
   end

   always_comb begin
      search_in = search_ff;
      cur_in    = cur_ff;
      cnt_in    = cnt_ff;
      if (acc) begin
         search_in = act && !res_push;
         cur_in    = (step && !win) ? next_off[OFF_W-1:0] : cur_eff;
         cnt_in    = cnt_eff;
         if (hit && !win && (cnt_eff != '1)) begin
            cnt_in = cnt_eff + OCC_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         search_ff <= 1'b0;
         cur_ff    <= '0;
         cnt_ff    <= '0;
      end else begin
         search_ff <= search_in;
         cur_ff    <= cur_in;
         cnt_ff    <= cnt_in;
      end
   end

   assign ctrl.shift = step;
   assign ctrl.clear = acc && first;
   assign ctrl.len   = len;

   generate
      for (genvar k = 0; k < WIN_DEPTH; k++) begin : g_cell
         if (k == 0) begin : g_head
            nbsf_cell #(.POS(k)) u_cell (
               .clock     (clock),
               .reset     (reset),
               .ctrl      (ctrl),
               .pattern   (pattern),
               .byte_in   (data),
               .valid_in  (1'b1),
               .byte_out  (cell_byte[k]),
               .valid_out (cell_valid[k]),
               .ok        (cell_ok[k])
            );
         end else begin : g_body
            nbsf_cell #(.POS(k)) u_cell (
               .clock     (clock),
               .reset     (reset),
               .ctrl      (ctrl),
               .pattern   (pattern),
               .byte_in   (cell_byte[k-1]),
               .valid_in  (cell_valid[k-1]),
               .byte_out  (cell_byte[k]),
               .valid_out (cell_valid[k]),
               .ok        (cell_ok[k])
            );
         end
      end
   endgenerate

   nbsf_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .push      (res_push),
      .push_data (res_data),
      .has_room  (has_room),
      .rsp       (rsp_bus)
   );

   assign req_bus.ready = has_room;

`ifndef ASSERT_OFF
   a_push_has_room: assert property (@(posedge clock) disable iff (reset)
      res_push |-> has_room)
      else $error("result pushed into a full output buffer");

   a_push_shows: assert property (@(posedge clock) disable iff (reset)
      res_push && !rsp_bus.valid |=> rsp_bus.valid)
      else $error("result pushed into an empty buffer did not show");

   a_search_ends_with_result: assert property (@(posedge clock) disable iff (reset)
      !search_in && search_ff && acc |-> res_push || first)
      else $error("search ended without a result");

   a_count_monotone: assert property (@(posedge clock) disable iff (reset)
      !(acc && first) |=> cnt_ff >= $past(cnt_ff))
      else $error("match count went down without a restart");
`endif

endmodule
`default_nettype wire

// ===== dv/nth_byte_sequence_finder_tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the n-th occurrence byte pattern finder.
module nth_byte_sequence_finder_tb;
   import nbsf_pkg::*;

   localparam int unsigned WIN_BYTES     = 15;
   localparam int unsigned SETTLE_CYCLES = 4;
   localparam logic [OFF_W-1:0] OFF_MAX  = '1;

   typedef struct {
      logic [7:0] data_byte;
      logic       first;
   } byte_word_type;

   logic                  clock     = 1'b0;
   logic                  reset     = 1'b1;
   logic                  csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = CSR_OCCURRENCE;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   nbsf_req_if req_bus ();
   nbsf_rsp_if rsp_bus ();

   nth_byte_sequence_finder #(.MAX_PATTERN(16)) dut (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Register copies as the block should hold them.
   logic [OCC_W-1:0]  occ_index   = '0;
   logic [OFF_W-1:0]  range_start = '0;
   logic [OFF_W-1:0]  range_stop  = '0;
   logic [OFF_W-1:0]  avail_size  = '0;
   logic [PLEN_W-1:0] pat_len     = '0;
   logic [PAT_W-1:0]  pattern     = '0;

   // Search state of the predictor.
   logic [7:0]       window [WIN_BYTES] = '{default: 8'h00};
   logic [OFF_W-1:0] cur_offset   = '0;
   logic [OCC_W-1:0] match_count  = '0;
   logic             searching    = 1'b0;
   int unsigned      window_fill  = 0;

   byte_word_type pending_bytes[$];
   result_type    expected_finds[$];
   int            bytes_in_flight = 0;
   int            error_count     = 0;
   int unsigned   send_idle_pct   = 35;
   int unsigned   recv_idle_pct   = 73;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic logic [7:0] pattern_byte(input int unsigned k);
      return (k < PAT_BYTES) ? pattern[k*8 +: 8] : 8'h00;
   endfunction

   task end_search(input logic hit, input logic [OFF_W-1:0] where);
      result_type r;
      r.found        = hit;
      r.match_offset = hit ? where : '0;
      expected_finds.insert(expected_finds.size(), r);
      searching = 1'b0;
   endtask

   // Advances the search by one accepted byte and queues any result it causes.
   task search_step(input logic [7:0] b, input logic start_flag);
      int unsigned      used;
      logic             hit;
      logic [OFF_W-1:0] limit;
      if (start_flag) begin
         foreach (window[i]) window[i] = 8'h00;
         match_count = '0;
         window_fill = 0;
         cur_offset  = range_start;
         if (range_start >= range_stop || avail_size == '0 || pat_len == '0) begin
            end_search(1'b0, '0);
            return;
         end
         searching = 1'b1;
      end
      if (!searching) return;

      used = (pat_len > PAT_BYTES) ? PAT_BYTES : pat_len;
      if (used == 0) begin
         end_search(1'b0, '0);
         return;
      end

      hit = (window_fill >= used - 1) && (pattern_byte(used - 1) == b);
      for (int k = 1; k < used; k++) begin
         if (pattern_byte(used - 1 - k) != window[k-1]) hit = 1'b0;
      end

      for (int i = WIN_BYTES - 1; i > 0; i--) window[i] = window[i-1];
      window[0] = b;
      if (window_fill < WIN_BYTES) window_fill++;

      if (hit) begin
         if (match_count >= occ_index) begin
            end_search(1'b1, cur_offset - OFF_W'(used - 1));
            return;
         end
         if (match_count != '1) match_count++;
      end

      cur_offset++;
      if (range_start >= range_stop) begin
         limit = range_stop;
      end else if (range_stop - range_start > avail_size) begin
         limit = range_start + avail_size;
      end else begin
         limit = range_stop;
      end
      if (cur_offset >= limit || cur_offset == '0) end_search(1'b0, '0);
   endtask

   // Byte driver: holds a word until it is taken, then loads the next one or idles.
   always @(posedge clock) begin
      byte_word_type w;
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            search_step(req_bus.data_byte, req_bus.first);
            bytes_in_flight--;
         end
         if (!req_bus.valid || req_bus.ready) begin
            if (pending_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               w = pending_bytes.pop_front();
               req_bus.valid     <= 1'b1;
               req_bus.data_byte <= w.data_byte;
               req_bus.first     <= w.first;
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // Result monitor with random back-pressure.
   always @(posedge clock) begin
      result_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (expected_finds.size() == 0) begin
            error_count++;
            $display("%0t: result with none expected: found=%0d offset=%h",
                     $time, rsp_bus.found, rsp_bus.match_offset);
         end else begin
            want = expected_finds.pop_front();
            if (rsp_bus.found !== want.found) begin
               error_count++;
               $display("%0t: found expected %0d, got %0d",
                        $time, want.found, rsp_bus.found);
            end
            if (rsp_bus.match_offset !== want.match_offset) begin
               error_count++;
               $display("%0t: match_offset expected %h, got %h",
                        $time, want.match_offset, rsp_bus.match_offset);
            end
         end
      end
      rsp_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   task write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] value);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      case (idx)
         CSR_OCCURRENCE: occ_index   = value[OCC_W-1:0];
         CSR_START:      range_start = value;
         CSR_END:        range_stop  = value;
         CSR_DATA_SIZE:  avail_size  = value;
         CSR_PAT_LEN:    pat_len     = value[PLEN_W-1:0];
         CSR_PAT_LOW:    pattern[63:0]   = value;
         CSR_PAT_HIGH:   pattern[127:64] = value;
         default: ;
      endcase
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task load_search(input logic [OCC_W-1:0] occ, input logic [OFF_W-1:0] first_off,
                    input logic [OFF_W-1:0] stop_off, input logic [OFF_W-1:0] size,
                    input logic [PLEN_W-1:0] plen, input logic [PAT_W-1:0] pat);
      write_csr(CSR_OCCURRENCE, CSR_DATA_W'(occ));
      write_csr(CSR_START, first_off);
      write_csr(CSR_END, stop_off);
      write_csr(CSR_DATA_SIZE, size);
      write_csr(CSR_PAT_LEN, CSR_DATA_W'(plen));
      write_csr(CSR_PAT_LOW, pat[63:0]);
      write_csr(CSR_PAT_HIGH, pat[127:64]);
   endtask

   task send_byte(input logic [7:0] b, input logic start_flag);
      byte_word_type w;
      w.data_byte = b;
      w.first     = start_flag;
      pending_bytes.insert(pending_bytes.size(), w);
      bytes_in_flight++;
   endtask

   // Waits until every word is taken and every result has come, then lets the
   // pipeline drain words that give no result.
   task settle();
      while (bytes_in_flight != 0 || expected_finds.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   initial begin
      int unsigned      random_bytes;
      int unsigned      kind;
      int unsigned      n;
      int unsigned      eff;
      int unsigned      span;
      int unsigned      used_len;
      int unsigned      extra;
      logic             tiled;
      logic [PLEN_W-1:0] plen;
      logic [7:0]       sym_a;
      logic [7:0]       sym_b;
      logic [7:0]       b;
      logic [OCC_W-1:0] occ;
      logic [OFF_W-1:0] r_start;
      logic [OFF_W-1:0] r_stop;
      logic [OFF_W-1:0] r_size;
      logic [PAT_W-1:0] pat;

      req_bus.valid     = 1'b0;
      req_bus.data_byte = 8'h00;
      req_bus.first     = 1'b0;
      rsp_bus.ready     = 1'b0;
      random_bytes      = 0;

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Overlapping matches of a two-byte pattern, with a restart part-way.
      load_search(1, 0, 8, OFF_MAX, 2, '0);
      send_byte(8'h00, 1'b1);
      send_byte(8'h00, 1'b0);
      send_byte(8'h00, 1'b1);
      send_byte(8'h00, 1'b0);
      send_byte(8'h00, 1'b0);
      settle();

      // Empty searches: start not below end, no data, no pattern; then an idle byte.
      load_search(0, 16, 16, 10, 1, PAT_W'(8'hFF));
      send_byte(8'hFF, 1'b1);
      settle();
      write_csr(CSR_END, 32);
      write_csr(CSR_DATA_SIZE, 0);
      send_byte(8'hFF, 1'b1);
      settle();
      write_csr(CSR_DATA_SIZE, 10);
      write_csr(CSR_PAT_LEN, 0);
      send_byte(8'hFF, 1'b1);
      send_byte(8'hFF, 1'b0);
      settle();

      // Over-long pattern length, full sixteen-byte pattern, offsets at the top.
      load_search(0, OFF_MAX - 31, OFF_MAX, OFF_MAX, 31, '1);
      for (int i = 0; i < 16; i++) send_byte(8'hFF, i == 0);
      settle();

      // The range end moves below the current offset while a search is open.
      load_search(0, 64, 128, OFF_MAX, 1, PAT_W'(8'h11));
      send_byte(8'h22, 1'b1);
      send_byte(8'h22, 1'b0);
      settle();
      write_csr(CSR_END, 65);
      send_byte(8'h33, 1'b0);
      settle();

      while (random_bytes < 400) begin
         if (random_bytes >= 266) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end else if (random_bytes >= 133) begin
            send_idle_pct = 73;
            recv_idle_pct = 35;
         end

         sym_a = 8'($urandom);
         sym_b = 8'($urandom);
         kind  = $urandom_range(0, 19);
         if (kind < 14)      plen = PLEN_W'($urandom_range(1, 3));
         else if (kind < 17) plen = PLEN_W'($urandom_range(4, 16));
         else if (kind < 19) plen = PLEN_W'($urandom_range(17, 31));
         else                plen = '0;
         for (int k = 0; k < PAT_BYTES; k++) pat[k*8 +: 8] = $urandom_range(0, 1) ? sym_a : sym_b;
         occ = ($urandom_range(0, 9) == 0) ? '1 : OCC_W'($urandom_range(0, 3));

         kind = $urandom_range(0, 9);
         if (kind == 0)      r_start = OFF_MAX - OFF_W'($urandom_range(0, 40));
         else if (kind == 1) r_start = {$urandom, $urandom};
         else                r_start = OFF_W'($urandom_range(0, 4096));
         n      = $urandom_range(1, 20);
         r_stop = r_start + OFF_W'(n);
         r_size = OFF_W'(n + $urandom_range(0, 50));
         kind   = $urandom_range(0, 19);
         case (kind)
            0: r_size = '0;
            1: r_stop = r_start - OFF_W'($urandom_range(0, 3));
            2, 3, 4, 5: r_size = OFF_W'($urandom_range(1, n));
            6: r_size = OFF_MAX;
            7: begin
               r_stop = OFF_MAX;
               r_size = OFF_W'(n);
            end
            default: ;
         endcase

         // Bytes that the range should take, capped to keep searches short.
         if (r_start >= r_stop || r_size == '0 || plen == '0) begin
            eff = 1;
         end else begin
            eff = 32'((r_stop - r_start < r_size)
                      ? ((r_stop - r_start > 40) ? OFF_W'(40) : r_stop - r_start)
                      : ((r_size > 40) ? OFF_W'(40) : r_size));
         end
         kind = $urandom_range(0, 19);
         if (kind < 14)      span = eff;
         else if (kind < 17) span = $urandom_range(1, eff);
         else                span = eff + $urandom_range(1, 3);

         load_search(occ, r_start, r_stop, r_size, plen, pat);

         // Now and then the previous search sees a few bytes under the new settings.
         if ($urandom_range(0, 4) == 0) begin
            extra = $urandom_range(1, 3);
            for (int i = 0; i < extra; i++) send_byte(8'($urandom), 1'b0);
         end

         used_len = (plen > PAT_BYTES) ? PAT_BYTES : ((plen == 0) ? 1 : plen);
         tiled    = $urandom_range(0, 1);
         for (int i = 0; i < span; i++) begin
            if (tiled) begin
               b = ($urandom_range(0, 9) == 0) ? ($urandom_range(0, 1) ? sym_a : sym_b)
                                               : pat[(i % used_len)*8 +: 8];
            end else begin
               b = ($urandom_range(0, 9) == 0) ? 8'($urandom)
                                               : ($urandom_range(0, 1) ? sym_a : sym_b);
            end
            send_byte(b, i == 0);
         end
         random_bytes += span;
         settle();
      end

      if (error_count == 0 && expected_finds.size() == 0) begin
         $display("nth_byte_sequence_finder_tb: done, clean");
      end else begin
         $display("nth_byte_sequence_finder_tb: done, errors");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("nth_byte_sequence_finder_tb: done, errors");
      $finish;
   end

endmodule

// ===== nth_byte_sequence_finder.f =====
rtl/nbsf_pkg.sv
rtl/nbsf_if.sv
rtl/nbsf_cell.sv
rtl/nbsf_out_buf.sv
rtl/nth_byte_sequence_finder.sv
dv/nth_byte_sequence_finder_tb.sv
